>>> hw/rtl/kipc_pkg.sv
// Shared types and constants for the k-inverse permutation count block.
// Depends on nothing; the top level imports it.
package kipc_pkg;

   localparam int MAX_N       = 1024;
   localparam int MAX_K       = 1024;
   localparam int LEN_W       = 11;
   localparam int COUNT_W     = 30;
   localparam int ROW_LEN     = MAX_K + 1;
   localparam int STORE_DEPTH = 2 * ROW_LEN;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   typedef logic [LEN_W-1:0]   len_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [ADDR_W-1:0]  addr_type;

   localparam count_type MODULUS   = COUNT_W'(1000000007);
   localparam count_type COUNT_ONE = COUNT_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROW,
      ST_DRAIN,
      ST_FINISH
   } state_type;

endpackage

>>> hw/rtl/kipc_ram.sv
// Generic RAM with one write port and two registered read ports.
// Stand-alone; sized by its WIDTH and DEPTH parameters.
module kipc_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 2050
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

>>> hw/rtl/k_inverse_permutation_count_top.sv
// Top level of the k-inverse permutation count block.
// Depends on kipc_pkg and on the kipc_ram row store.
//
// Usage. A request item carries a permutation length n and an inversion
// count k. The block answers with one response item: the number of
// permutations of 1..n with exactly k inverse pairs, modulo 1000000007.
// Values of n or k above 1024 are treated as 1024. A length of zero
// answers zero.
//
// Both channels use valid and stall. An item moves at a rising edge where
// valid is high and stall is low. The block works on one request at a time
// and stalls the request channel while it is busy.
//
// Schedule. The rows are built one after another in a two-bank row
// store. Each row is issued one entry per cycle, followed by a drain so
// the row just written has reached the store before the next row reads
// it. The response is offered once the last row has drained; a length of
// zero goes straight to the answer. The block returns to idle as the
// response is offered, so the next request can then be taken. The one
// write per cycle into the row store and the drain between rows set the
// spacing of back-to-back items.
//
// The response sits in an output register. While the receiver stalls, the
// block still accepts the next request and computes it; it only waits at
// the end if the earlier response has not been taken yet.
//
// Reset clears the control state and drops any pending response. The row
// store needs no clearing: each request writes every entry before reading it.
module k_inverse_permutation_count_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  kipc_pkg::len_type   req_perm_length,
   input  kipc_pkg::len_type   req_inversion_target,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output kipc_pkg::count_type rsp_perm_count
);

   import kipc_pkg::*;

   // Sequencer state and loop counters.
   state_type state_ff, state_in;
   len_type   n_ff, n_in;
   len_type   k_ff, k_in;
   len_type   i_ff, i_in;
   len_type   j_ff, j_in;
   logic      drain_ff, drain_in;
   logic      issue;
   logic      clear_result;

   // Output register.
   logic      rsp_valid_ff, rsp_valid_in;
   count_type rsp_count_ff, rsp_count_in;
   count_type result_ff, result_in;

   // Saturated request fields.
   len_type   n_sat;
   len_type   k_sat;

   // Row store addressing. Row i lives in bank i[0]; the previous row in
   // the other bank.
   addr_type  cur_base;
   addr_type  prev_base;
   addr_type  rd_addr_a;
   addr_type  rd_addr_b;
   len_type   j_back;

   // Stage 1: read data arrives from the store.
   logic      s1_valid_ff, s1_first_ff, s1_sub_ff, s1_mask_ff, s1_last_ff;
   addr_type  s1_wr_addr_ff;
   count_type rd_data_a;
   count_type rd_data_b;
   count_type prev_add;
   count_type prev_drop;
   logic [COUNT_W:0] delta_sum;
   count_type delta_in;

   // Stage 2: window update and write back.
   logic      s2_valid_ff, s2_first_ff, s2_last_ff;
   addr_type  s2_wr_addr_ff;
   count_type s2_delta_ff;
   count_type window_ff, window_in;
   logic [COUNT_W:0] window_sum;
   count_type window_mod;
   count_type wr_data;

   assign n_sat = (req_perm_length > LEN_W'(MAX_N)) ? LEN_W'(MAX_N) : req_perm_length;
   assign k_sat = (req_inversion_target > LEN_W'(MAX_K)) ?
                  LEN_W'(MAX_K) : req_inversion_target;

   assign cur_base  = i_ff[0] ? ADDR_W'(ROW_LEN) : '0;
   assign prev_base = i_ff[0] ? '0 : ADDR_W'(ROW_LEN);
   assign j_back    = j_ff - i_ff;
   assign rd_addr_a = prev_base + ADDR_W'(j_ff);
   assign rd_addr_b = prev_base + ADDR_W'(j_back);

   // Sequencer: one entry of the current row is issued per cycle in ST_ROW.
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      drain_in     = drain_ff;
      issue        = 1'b0;
      clear_result = 1'b0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_count_in = rsp_count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               n_in         = n_sat;
               k_in         = k_sat;
               i_in         = LEN_W'(1);
               j_in         = '0;
               clear_result = 1'b1;
               state_in     = (n_sat == '0) ? ST_FINISH : ST_ROW;
            end
         end
         ST_ROW: begin
            issue = 1'b1;
            if (j_ff == k_ff) begin
               drain_in = 1'b0;
               state_in = ST_DRAIN;
            end else begin
               j_in = j_ff + LEN_W'(1);
            end
         end
         ST_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               if (i_ff == n_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  i_in     = i_ff + LEN_W'(1);
                  j_in     = '0;
                  state_in = ST_ROW;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      k_ff         <= k_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      drain_ff     <= drain_in;
      rsp_count_ff <= rsp_count_in;
      result_ff    <= result_in;
   end

   // Stage 1. The first row reads as zero, since row zero is all zero.
   // The dropped term only applies once the window is i entries wide.
   assign prev_add  = s1_mask_ff ? '0 : rd_data_a;
   assign prev_drop = (s1_mask_ff || !s1_sub_ff) ? '0 : rd_data_b;
   assign delta_sum = {1'b0, prev_add} + {1'b0, MODULUS - prev_drop};
   assign delta_in  = (delta_sum >= {1'b0, MODULUS}) ?
                      COUNT_W'(delta_sum - {1'b0, MODULUS}) : COUNT_W'(delta_sum);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_first_ff   <= (j_ff == '0);
      s1_sub_ff     <= (j_ff >= i_ff);
      s1_mask_ff    <= (i_ff == LEN_W'(1));
      s1_last_ff    <= (j_ff == k_ff) && (i_ff == n_ff);
      s1_wr_addr_ff <= cur_base + ADDR_W'(j_ff);
      s2_first_ff   <= s1_first_ff;
      s2_last_ff    <= s1_last_ff;
      s2_wr_addr_ff <= s1_wr_addr_ff;
      s2_delta_ff   <= delta_in;
      window_ff     <= window_in;
   end

   // Stage 2. Entry zero of each row is one and seeds the window with the
   // previous row's entry zero; later entries add the delta to the window.
   assign window_sum = {1'b0, window_ff} + {1'b0, s2_delta_ff};
   assign window_mod = (window_sum >= {1'b0, MODULUS}) ?
                       COUNT_W'(window_sum - {1'b0, MODULUS}) : COUNT_W'(window_sum);

   always_comb begin
      window_in = window_ff;
      wr_data   = window_mod;
      if (s2_first_ff) begin
         wr_data = COUNT_ONE;
      end
      if (s2_valid_ff) begin
         window_in = s2_first_ff ? s2_delta_ff : window_mod;
      end
   end

   // The last entry of the last row is the answer.
   always_comb begin
      result_in = result_ff;
      if (clear_result) begin
         result_in = '0;
      end else if (s2_valid_ff && s2_last_ff) begin
         result_in = wr_data;
      end
   end

   kipc_ram #(
      .WIDTH(COUNT_W),
      .DEPTH(STORE_DEPTH)
   ) u_row_store (
      .clock     (clock),
      .wr_en     (s2_valid_ff),
      .wr_addr   (s2_wr_addr_ff),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_perm_count = rsp_count_ff;

   // A write back never lands on the entry read on port a in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && issue) |-> (s2_wr_addr_ff != rd_addr_a))
      else $error("row store write collides with a read");

   // Every value stored is already reduced.
   assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (wr_data < MODULUS))
      else $error("unreduced value written to the row store");

   // The pipeline has drained before the answer is handed out.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("answer taken while the pipeline is busy");

   // A pending, stalled response holds the block in its finish state.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_FINISH))
      else $error("response register overwritten while stalled");

   // The entry index stays within the requested target.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROW) |-> (j_ff <= k_ff))
      else $error("entry index ran past the target");

endmodule
